// ===== rtl/rbsc_pkg.sv =====
`default_nettype none

package rbsc_pkg;

    // pipeline geometry
    localparam int unsigned N_STAGES      = 72;
    localparam int unsigned STG_ENTRY     = 0;
    localparam int unsigned STG_VEL       = 1;
    localparam int unsigned STG_SQUARE    = 2;
    localparam int unsigned STG_POS       = 3;
    localparam int unsigned STG_SQRT_0    = 4;
    localparam int unsigned STG_SQRT_N    = 35;
    localparam int unsigned STG_MDIV_N    = 28;
    localparam int unsigned STG_NDIV_SET  = 36;
    localparam int unsigned STG_NDIV_0    = 37;
    localparam int unsigned STG_NDIV_N    = 65;
    localparam int unsigned STG_REL_MUL   = 66;
    localparam int unsigned STG_REL_SUM   = 67;
    localparam int unsigned STG_REST      = 68;
    localparam int unsigned STG_FRAC      = 69;
    localparam int unsigned STG_ALONG     = 70;
    localparam int unsigned STG_APPLY     = 71;

    localparam int unsigned SQRT_TOP_BIT  = 62;
    localparam int unsigned MFRAC_BITS    = 24;
    localparam int unsigned NORM_BITS     = 28;

    // register reset values
    localparam logic signed [31:0] GRAVITY_X_RST   = 32'sd0;
    localparam logic signed [31:0] GRAVITY_Y_RST   = -32'sd642253;
    localparam logic        [16:0] TIME_STEP_RST   = 17'd1092;
    localparam logic        [16:0] RESTITUTION_RST = 17'd65536;
    localparam logic        [17:0] ONE_Q16         = 18'd65536;

    typedef enum logic [1:0] {
        CFG_GRAVITY_X   = 2'd0,
        CFG_GRAVITY_Y   = 2'd1,
        CFG_TIME_STEP   = 2'd2,
        CFG_RESTITUTION = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_NONE       = 2'd0,
        ST_IMPULSE    = 2'd1,
        ST_COINCIDENT = 2'd2,
        ST_SATURATED  = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic        [16:0] dt;
        logic        [16:0] e;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] pax;
        logic signed [31:0] pay;
        logic signed [31:0] vax;
        logic signed [31:0] vay;
        logic        [31:0] ma;
        logic signed [31:0] pbx;
        logic signed [31:0] pby;
        logic signed [31:0] vbx;
        logic signed [31:0] vby;
        logic        [31:0] mb;
        logic signed [49:0] gpx;
        logic signed [49:0] gpy;
        logic signed [49:0] ppx;
        logic signed [49:0] ppy;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic        [32:0] tot;
        logic        [57:0] rem_fa;
        logic        [57:0] rem_fb;
        logic        [24:0] fa;
        logic        [24:0] fb;
        logic               sgnx;
        logic               sgny;
        logic               coinc;
        logic        [30:0] ax;
        logic        [30:0] ay;
        logic        [61:0] sqx;
        logic        [61:0] sqy;
        logic        [62:0] sv;
        logic        [63:0] sr;
        logic        [31:0] len;
        logic        [58:0] rem_x;
        logic        [58:0] rem_y;
        logic        [28:0] qx;
        logic        [28:0] qy;
        logic signed [62:0] prx;
        logic signed [62:0] pry;
        logic signed [63:0] rel;
        logic               pos;
        logic        [34:0] sval;
        logic        [36:0] q;
        logic        [36:0] da;
        logic        [36:0] db;
        logic        [36:0] mxa;
        logic        [36:0] mya;
        logic        [36:0] mxb;
        logic        [36:0] myb;
        logic               clip;
        status_t            status;
    } pl_t;

    // saturate to 32 bits, msb of the result flags a clip
    function automatic logic [32:0] sat32(input logic signed [39:0] x);
        logic [32:0] r;
        begin
            if (x > 40'sd2147483647) begin
                r = {1'b1, 32'h7FFF_FFFF};
            end else if (x < -40'sd2147483648) begin
                r = {1'b1, 32'h8000_0000};
            end else begin
                r = {1'b0, x[31:0]};
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rigid_body_step_and_collision_2d.sv =====
`default_nettype none

// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  kind, two bodies (pos, vel, mass)
// m_        out        m_valid / m_ready  A pos and vel, B vel, status
// cfg_      in         cfg_we             cfg_index, cfg_wdata (no read-back)
//
// one item enters per cycle unless the pipeline is full and the output stalled;
// each item passes through every stage to the output register, the depth set by
// the 32-step square root and 29-step normal divide unrolled into one stage per step
// aresetn (synchronous) clears the valid bits and loads register defaults
// each stage holds its item only while the stage after it is stalled, so a
// stalled output still lets items enter until every bubble is filled

module rigid_body_step_and_collision_2d
    import rbsc_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,

    input  wire                cfg_we,
    input  wire         [1:0]  cfg_index,
    input  wire         [31:0] cfg_wdata,

    input  wire                s_valid,
    output logic               s_ready,
    input  wire                s_kind,
    input  wire  signed [31:0] s_pos_a_x,
    input  wire  signed [31:0] s_pos_a_y,
    input  wire  signed [31:0] s_vel_a_x,
    input  wire  signed [31:0] s_vel_a_y,
    input  wire         [31:0] s_mass_a,
    input  wire  signed [31:0] s_pos_b_x,
    input  wire  signed [31:0] s_pos_b_y,
    input  wire  signed [31:0] s_vel_b_x,
    input  wire  signed [31:0] s_vel_b_y,
    input  wire         [31:0] s_mass_b,

    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [31:0] m_new_pos_a_x,
    output logic signed [31:0] m_new_pos_a_y,
    output logic signed [31:0] m_new_vel_a_x,
    output logic signed [31:0] m_new_vel_a_y,
    output logic signed [31:0] m_new_vel_b_x,
    output logic signed [31:0] m_new_vel_b_y,
    output logic        [1:0]  m_status
);

    // configuration registers
    logic signed [31:0] gravity_x_reg;
    logic signed [31:0] gravity_y_reg;
    logic        [16:0] time_step_reg;
    logic        [16:0] restitution_reg;
    cfg_t               cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_x_reg   <= GRAVITY_X_RST;
            gravity_y_reg   <= GRAVITY_Y_RST;
            time_step_reg   <= TIME_STEP_RST;
            restitution_reg <= RESTITUTION_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GRAVITY_X:   gravity_x_reg   <= cfg_wdata;
                CFG_GRAVITY_Y:   gravity_y_reg   <= cfg_wdata;
                CFG_TIME_STEP:   time_step_reg   <= cfg_wdata[16:0];
                CFG_RESTITUTION: restitution_reg <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    assign cfg = '{gx: gravity_x_reg, gy: gravity_y_reg,
                   dt: time_step_reg, e: restitution_reg};

    // work done by one stage; everything is computed for both kinds and the
    // kind only steers the writes that would clobber pass-through fields
    function automatic pl_t stage_fn(input int unsigned s, input pl_t p, input cfg_t c);
        pl_t                o;
        logic signed [17:0] dts;
        logic signed [39:0] wide;
        logic        [32:0] satv;
        logic        [32:0] abx;
        logic        [32:0] aby;
        logic        [63:0] v64;
        logic        [63:0] r64;
        logic        [63:0] b64;
        logic        [63:0] t64;
        logic        [59:0] dd;
        logic        [57:0] dm;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic signed [29:0] nxs;
        logic signed [29:0] nys;
        logic        [52:0] qprod;
        logic        [61:0] fpa;
        logic        [61:0] fpb;
        logic        [65:0] mpxa;
        logic        [65:0] mpya;
        logic        [65:0] mpxb;
        logic        [65:0] mpyb;
        logic signed [38:0] dlt;
        logic               clip;
        int unsigned        k;
        int unsigned        j;
        begin
            o    = p;
            dts  = $signed({1'b0, c.dt});
            clip = p.clip;

            if (s == STG_ENTRY) begin
                o.gpx    = c.gx * dts;
                o.gpy    = c.gy * dts;
                o.dx     = 33'(p.pbx) - 33'(p.pax);
                o.dy     = 33'(p.pby) - 33'(p.pay);
                o.tot    = {1'b0, p.ma} + {1'b0, p.mb};
                o.rem_fa = {2'b00, p.mb, 24'd0};
                o.rem_fb = {2'b00, p.ma, 24'd0};
                o.fa     = '0;
                o.fb     = '0;
                o.clip   = 1'b0;
                clip     = 1'b0;
            end

            if (s == STG_VEL) begin
                if (!p.kind) begin
                    wide  = 40'(p.vax) + 40'(p.gpx >>> 16);
                    satv  = sat32(wide);
                    o.vax = satv[31:0];
                    clip  = clip | satv[32];
                    wide  = 40'(p.vay) + 40'(p.gpy >>> 16);
                    satv  = sat32(wide);
                    o.vay = satv[31:0];
                    clip  = clip | satv[32];
                end
                abx = p.dx[32] ? 33'(-p.dx) : 33'(p.dx);
                aby = p.dy[32] ? 33'(-p.dy) : 33'(p.dy);
                // halve together until both fit in 31 bits (two steps at most)
                if (|(abx[32:31] | aby[32:31])) begin
                    abx = abx >> 1;
                    aby = aby >> 1;
                end
                if (|(abx[32:31] | aby[32:31])) begin
                    abx = abx >> 1;
                    aby = aby >> 1;
                end
                o.ax    = abx[30:0];
                o.ay    = aby[30:0];
                o.sgnx  = p.dx[32];
                o.sgny  = p.dy[32];
                o.coinc = (p.dx == 33'sd0) && (p.dy == 33'sd0);
            end

            if (s == STG_SQUARE) begin
                if (!p.kind) begin
                    o.ppx = p.vax * dts;
                    o.ppy = p.vay * dts;
                end
                o.sqx = p.ax * p.ax;
                o.sqy = p.ay * p.ay;
            end

            if (s == STG_POS) begin
                if (!p.kind) begin
                    wide  = 40'(p.pax) + 40'(p.ppx >>> 16);
                    satv  = sat32(wide);
                    o.pax = satv[31:0];
                    clip  = clip | satv[32];
                    wide  = 40'(p.pay) + 40'(p.ppy >>> 16);
                    satv  = sat32(wide);
                    o.pay = satv[31:0];
                    clip  = clip | satv[32];
                end
                o.sv = {1'b0, p.sqx} + {1'b0, p.sqy};
                o.sr = '0;
            end

            // integer square root, one result bit per stage
            if (s >= STG_SQRT_0 && s <= STG_SQRT_N) begin
                k   = s - STG_SQRT_0;
                b64 = 64'd1 << (SQRT_TOP_BIT - 2 * k);
                v64 = {1'b0, p.sv};
                r64 = p.sr;
                t64 = r64 + b64;
                if (v64 >= t64) begin
                    v64 = v64 - t64;
                    r64 = (r64 >> 1) + b64;
                end else begin
                    r64 = r64 >> 1;
                end
                o.sv = v64[62:0];
                o.sr = r64;
            end

            // mass fractions, restoring divide alongside the root
            if (s >= STG_SQRT_0 && s <= STG_MDIV_N) begin
                j  = STG_MDIV_N - s;
                dm = 58'(p.tot) << j;
                if (p.rem_fa >= dm) begin
                    o.rem_fa = p.rem_fa - dm;
                    o.fa     = p.fa | (25'd1 << j);
                end
                if (p.rem_fb >= dm) begin
                    o.rem_fb = p.rem_fb - dm;
                    o.fb     = p.fb | (25'd1 << j);
                end
            end

            if (s == STG_NDIV_SET) begin
                o.len   = (p.sr[31:0] == 32'd0) ? 32'd1 : p.sr[31:0];
                o.rem_x = {p.ax, 28'd0};
                o.rem_y = {p.ay, 28'd0};
                o.qx    = '0;
                o.qy    = '0;
            end

            // normal component magnitudes in unsigned Q1.28, one quotient bit per stage
            if (s >= STG_NDIV_0 && s <= STG_NDIV_N) begin
                j  = STG_NDIV_N - s;
                dd = 60'(p.len) << j;
                if ({1'b0, p.rem_x} >= dd) begin
                    o.rem_x = 59'({1'b0, p.rem_x} - dd);
                    o.qx    = p.qx | (29'd1 << j);
                end
                if ({1'b0, p.rem_y} >= dd) begin
                    o.rem_y = 59'({1'b0, p.rem_y} - dd);
                    o.qy    = p.qy | (29'd1 << j);
                end
            end

            if (s == STG_REL_MUL) begin
                nxs   = p.sgnx ? -$signed({1'b0, p.qx}) : $signed({1'b0, p.qx});
                nys   = p.sgny ? -$signed({1'b0, p.qy}) : $signed({1'b0, p.qy});
                dvx   = 33'(p.vax) - 33'(p.vbx);
                dvy   = 33'(p.vay) - 33'(p.vby);
                o.prx = dvx * nxs;
                o.pry = dvy * nys;
            end

            if (s == STG_REL_SUM) begin
                o.rel  = 64'(p.prx) + 64'(p.pry);
                o.pos  = (o.rel > 64'sd0);
                o.sval = o.rel[62:28];
                // both masses zero: equal halves
                if (p.tot == 33'd0) begin
                    o.fa = 25'd1 << (MFRAC_BITS - 1);
                    o.fb = 25'd1 << (MFRAC_BITS - 1);
                end
            end

            if (s == STG_REST) begin
                qprod = p.sval * (ONE_Q16 + 18'(c.e));
                o.q   = qprod[52:16];
            end

            if (s == STG_FRAC) begin
                fpa  = p.q * p.fa;
                fpb  = p.q * p.fb;
                o.da = fpa[60:24];
                o.db = fpb[60:24];
            end

            if (s == STG_ALONG) begin
                mpxa  = p.da * p.qx;
                mpya  = p.da * p.qy;
                mpxb  = p.db * p.qx;
                mpyb  = p.db * p.qy;
                o.mxa = mpxa[64:28];
                o.mya = mpya[64:28];
                o.mxb = mpxb[64:28];
                o.myb = mpyb[64:28];
            end

            if (s == STG_APPLY) begin
                if (p.kind) begin
                    if (p.coinc) begin
                        o.status = ST_COINCIDENT;
                    end else if (p.pos) begin
                        dlt   = p.sgnx ? -39'(p.mxa) : 39'(p.mxa);
                        satv  = sat32(40'(p.vax) - 40'(dlt));
                        o.vax = satv[31:0];
                        clip  = clip | satv[32];
                        dlt   = p.sgny ? -39'(p.mya) : 39'(p.mya);
                        satv  = sat32(40'(p.vay) - 40'(dlt));
                        o.vay = satv[31:0];
                        clip  = clip | satv[32];
                        dlt   = p.sgnx ? -39'(p.mxb) : 39'(p.mxb);
                        satv  = sat32(40'(p.vbx) + 40'(dlt));
                        o.vbx = satv[31:0];
                        clip  = clip | satv[32];
                        dlt   = p.sgny ? -39'(p.myb) : 39'(p.myb);
                        satv  = sat32(40'(p.vby) + 40'(dlt));
                        o.vby = satv[31:0];
                        clip  = clip | satv[32];
                        o.status = clip ? ST_SATURATED : ST_IMPULSE;
                    end else begin
                        o.status = ST_NONE;
                    end
                end else begin
                    o.status = clip ? ST_SATURATED : ST_NONE;
                end
            end

            o.clip = clip;
            return o;
        end
    endfunction

    // incoming item
    pl_t in_pl;

    always_comb begin
        in_pl        = '0;
        in_pl.kind   = s_kind;
        in_pl.pax    = s_pos_a_x;
        in_pl.pay    = s_pos_a_y;
        in_pl.vax    = s_vel_a_x;
        in_pl.vay    = s_vel_a_y;
        in_pl.ma     = s_mass_a;
        in_pl.pbx    = s_pos_b_x;
        in_pl.pby    = s_pos_b_y;
        in_pl.vbx    = s_vel_b_x;
        in_pl.vby    = s_vel_b_y;
        in_pl.mb     = s_mass_b;
        in_pl.status = ST_NONE;
    end

    // pipeline
    pl_t                 pipe_reg  [N_STAGES];
    pl_t                 pipe_next [N_STAGES];
    logic [N_STAGES-1:0] valid_reg;
    logic [N_STAGES-1:0] stage_ready;

    for (genvar g = 0; g < N_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            always_comb pipe_next[g] = stage_fn(g, in_pl, cfg);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[g] <= 1'b0;
                end else if (stage_ready[g]) begin
                    valid_reg[g] <= s_valid;
                end
            end
        end else begin : g_rest
            always_comb pipe_next[g] = stage_fn(g, pipe_reg[g-1], cfg);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[g] <= 1'b0;
                end else if (stage_ready[g]) begin
                    valid_reg[g] <= valid_reg[g-1];
                end
            end
        end

        if (g == N_STAGES - 1) begin : g_last_rdy
            assign stage_ready[g] = !valid_reg[g] || m_ready;
        end else begin : g_mid_rdy
            assign stage_ready[g] = !valid_reg[g] || stage_ready[g+1];
        end

        // payload carries no reset
        always_ff @(posedge aclk) begin
            if (stage_ready[g]) begin
                pipe_reg[g] <= pipe_next[g];
            end
        end
    end

    assign s_ready       = stage_ready[0];
    assign m_valid       = valid_reg[N_STAGES-1];
    assign m_new_pos_a_x = pipe_reg[N_STAGES-1].pax;
    assign m_new_pos_a_y = pipe_reg[N_STAGES-1].pay;
    assign m_new_vel_a_x = pipe_reg[N_STAGES-1].vax;
    assign m_new_vel_a_y = pipe_reg[N_STAGES-1].vay;
    assign m_new_vel_b_x = pipe_reg[N_STAGES-1].vbx;
    assign m_new_vel_b_y = pipe_reg[N_STAGES-1].vby;
    assign m_status      = pipe_reg[N_STAGES-1].status;

    // input only backs up once every stage holds an item
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_reg))
        else $error("input blocked with a bubble in the pipeline");

    // an integration step never reports an impulse or coincidence
    a_step_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !pipe_reg[N_STAGES-1].kind) |->
        (m_status == ST_NONE || m_status == ST_SATURATED))
        else $error("collision status on an integration item");

    // coincident status comes only from a collision item with coincident positions
    a_coinc_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_COINCIDENT) |->
        (pipe_reg[N_STAGES-1].kind && pipe_reg[N_STAGES-1].coinc))
        else $error("coincident status without coincident positions");

endmodule

`default_nettype wire
